[rtl/wps_pkg.sv]
// ----------------------------------------------------------------------------
// wps_pkg - shared types and constants for the weighted parent selector
// Holds the fixed field widths, the node weight constants and the one-hot
// encoding of the control sequencer.
// ----------------------------------------------------------------------------
package wps_pkg;

   // Fixed field widths
   localparam int unsigned RAND_W  = 31;
   localparam int unsigned LIMIT_W = 11;
   localparam int unsigned OUT_W   = 10;

   // Node weight is its child count plus ROOT_WEIGHT; each new node adds
   // ROOT_WEIGHT for itself and one for its parent's extra child.
   localparam int unsigned ROOT_WEIGHT = 2;
   localparam int unsigned WEIGHT_STEP = ROOT_WEIGHT + 1;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

   typedef enum logic [6:0] {
      ST_INIT  = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_DIV   = 7'b0000100,
      ST_WALK  = 7'b0001000,
      ST_DEPTH = 7'b0010000,
      ST_UPD   = 7'b0100000,
      ST_NEW   = 7'b1000000
   } wps_state_type;

endpackage

[rtl/wps_ram.sv]
// ----------------------------------------------------------------------------
// wps_ram - single-port-write, single-port-read synchronous memory
// One write and one registered read per cycle; read data follows the address in the next cycle.
// ----------------------------------------------------------------------------
module wps_ram #(
   parameter int unsigned WIDTH = 10,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/wps_mod.sv]
// ----------------------------------------------------------------------------
// wps_mod - iterative remainder unit
// Restoring division, one dividend bit per cycle; the remainder is valid
// in the cycle that done is high.
// ----------------------------------------------------------------------------
module wps_mod
   import wps_pkg::*;
#(
   parameter int unsigned DIV_W = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAND_W-1:0] dividend,
   input  logic [DIV_W-1:0]  divisor,
   output logic              done,
   output logic [DIV_W-1:0]  remainder
);

   localparam int unsigned CNT_W = $clog2(RAND_W + 1);

   logic              run_ff,  run_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic [RAND_W-1:0] num_ff,  num_in;
   logic [DIV_W-1:0]  div_ff,  div_in;
   logic [DIV_W-1:0]  rem_ff,  rem_in;
   logic [DIV_W:0]    trial;
   logic              fits;

   always_comb begin
      trial  = {rem_ff, num_ff[RAND_W-1]};
      fits   = trial >= {1'b0, div_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(RAND_W);
         num_in = dividend;
         div_in = divisor;
         rem_in = '0;
      end else if (run_ff) begin
         // shift in one dividend bit, subtract when the divisor fits
         rem_in = fits ? DIV_W'(trial - {1'b0, div_ff}) : DIV_W'(trial);
         num_in = {num_ff[RAND_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < div_ff)
      else $error("remainder not below divisor");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff)
      else $error("done raised while still iterating");

endmodule

[rtl/weighted_parent_selector.sv]
// ----------------------------------------------------------------------------
// weighted_parent_selector - preferential attachment tree builder
// Picks a parent for each new node with probability proportional to the
// parent's child count plus two, stores the new node's depth and tracks
// the deepest node created.
// ----------------------------------------------------------------------------
//
//   channel   ports                              flow
//   -------   --------------------------------   -------------------------------
//   request   start, busy, req_random_word       in on start & !busy
//   response  rsp_strobe, rsp_* fields           out, one cycle, no back-pressure
//   config    csr_valid, csr_ready, csr_dir_limit in on csr_valid & csr_ready
//
// Cycles: a transaction against a full tree answers in the next cycle.
//   Otherwise the remainder unit runs its 31 steps and raises done, then the
//   weight walk reads the child-count memory in turn from node zero up to the
//   chosen parent, and the depth read and write-back follow before the strobe.
//   The length of the walk grows with the index of the chosen parent.
// Reset: synchronous; the clearing state ST_INIT writes entry zero of both memories,
//   with busy high, before the first transaction is taken.
// Stalls: the receiver cannot stall; busy stays high until the write-back ends.
// ----------------------------------------------------------------------------
module weighted_parent_selector
   import wps_pkg::*;
#(
   parameter int unsigned MAX_NODES = 1024
) (
   input  logic               clock,
   input  logic               reset,
   // request
   input  logic               start,
   output logic               busy,
   input  logic [RAND_W-1:0]  req_random_word,
   // configuration
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [LIMIT_W-1:0] csr_dir_limit,
   // response
   output logic               rsp_strobe,
   output logic [OUT_W-1:0]   rsp_new_node,
   output logic [OUT_W-1:0]   rsp_parent_node,
   output logic [OUT_W-1:0]   rsp_node_depth,
   output logic [OUT_W-1:0]   rsp_deepest,
   output logic               rsp_full_res
);

   localparam int unsigned NODE_W  = $clog2(MAX_NODES);
   localparam int unsigned TOTAL_W = $clog2(MAX_NODES + 1);
   localparam int unsigned WS_W    = $clog2(3 * MAX_NODES);
   localparam int unsigned SUM_W   = WS_W + 1;

   wps_state_type      state_ff, state_in;
   logic [TOTAL_W-1:0] node_total_ff, node_total_in;
   logic [WS_W-1:0]    ws_ff, ws_in;
   logic [NODE_W-1:0]  maxd_ff, maxd_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [WS_W-1:0]    token_ff, token_in;
   logic [WS_W-1:0]    acc_ff, acc_in;
   logic [NODE_W-1:0]  issue_ff, issue_in;
   logic               pend_ff, pend_in;
   logic [NODE_W-1:0]  pend_idx_ff, pend_idx_in;
   logic [NODE_W-1:0]  pick_ff, pick_in;
   logic [NODE_W-1:0]  pick_cnt_ff, pick_cnt_in;

   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [OUT_W-1:0]   rsp_new_ff, rsp_new_in;
   logic [OUT_W-1:0]   rsp_parent_ff, rsp_parent_in;
   logic [OUT_W-1:0]   rsp_depth_ff, rsp_depth_in;
   logic [OUT_W-1:0]   rsp_deepest_ff, rsp_deepest_in;
   logic               rsp_full_ff, rsp_full_in;

   // memory ports
   logic               cw_en, dw_en;
   logic [NODE_W-1:0]  cw_addr, dw_addr;
   logic [NODE_W-1:0]  cw_data, dw_data;
   logic [NODE_W-1:0]  cr_data, dr_data;

   // remainder unit
   logic               div_start, div_done;
   logic [WS_W-1:0]    div_rem;

   logic               accept, tree_full, hit;
   logic [SUM_W-1:0]   walk_sum;
   logic [NODE_W-1:0]  new_idx, last_idx, new_depth;

   wps_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_child_ram (
      .clock   (clock),
      .wr_en   (cw_en),
      .wr_addr (cw_addr),
      .wr_data (cw_data),
      .rd_addr (issue_ff),
      .rd_data (cr_data)
   );

   wps_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_depth_ram (
      .clock   (clock),
      .wr_en   (dw_en),
      .wr_addr (dw_addr),
      .wr_data (dw_data),
      .rd_addr (pick_ff),
      .rd_data (dr_data)
   );

   wps_mod #(.DIV_W(WS_W)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_random_word),
      .divisor   (ws_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      accept    = start && (state_ff == ST_IDLE);
      // limit above MAX_NODES acts as MAX_NODES; 0 or 1 means full at once
      tree_full = (32'(node_total_ff) >= 32'(limit_ff)) ||
                  (32'(node_total_ff) >= MAX_NODES);
      new_idx   = NODE_W'(node_total_ff);
      last_idx  = NODE_W'(node_total_ff - TOTAL_W'(1));
      walk_sum  = SUM_W'(acc_ff) + SUM_W'(cr_data) + SUM_W'(ROOT_WEIGHT);
      // last node is the fallback parent if the walk runs out
      hit       = (walk_sum >= SUM_W'(token_ff)) || (pend_idx_ff == last_idx);
      new_depth = dr_data + NODE_W'(1);

      state_in      = state_ff;
      node_total_in = node_total_ff;
      ws_in         = ws_ff;
      maxd_in       = maxd_ff;
      limit_in      = csr_valid ? csr_dir_limit : limit_ff;
      token_in      = token_ff;
      acc_in        = acc_ff;
      issue_in      = issue_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      pick_in       = pick_ff;
      pick_cnt_in   = pick_cnt_ff;

      rsp_strobe_in  = 1'b0;
      rsp_new_in     = rsp_new_ff;
      rsp_parent_in  = rsp_parent_ff;
      rsp_depth_in   = rsp_depth_ff;
      rsp_deepest_in = rsp_deepest_ff;
      rsp_full_in    = rsp_full_ff;

      div_start = 1'b0;
      cw_en     = 1'b0;
      cw_addr   = pick_ff;
      cw_data   = '0;
      dw_en     = 1'b0;
      dw_addr   = new_idx;
      dw_data   = new_depth;

      unique case (state_ff)
         ST_INIT: begin
            // clear the root entry of both memories
            cw_en    = 1'b1;
            cw_addr  = '0;
            dw_en    = 1'b1;
            dw_addr  = '0;
            dw_data  = '0;
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (tree_full) begin
                  // answer at once, leave state untouched
                  rsp_strobe_in  = 1'b1;
                  rsp_new_in     = '0;
                  rsp_parent_in  = '0;
                  rsp_depth_in   = '0;
                  rsp_deepest_in = OUT_W'(maxd_ff);
                  rsp_full_in    = 1'b1;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               token_in = div_rem + WS_W'(1);
               acc_in   = '0;
               issue_in = '0;
               pend_in  = 1'b0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            // issue the next read while summing the one that just returned
            issue_in    = issue_ff + NODE_W'(1);
            pend_in     = 1'b1;
            pend_idx_in = issue_ff;
            if (pend_ff) begin
               if (hit) begin
                  pick_in     = pend_idx_ff;
                  pick_cnt_in = cr_data;
                  state_in    = ST_DEPTH;
               end else begin
                  acc_in = WS_W'(walk_sum);
               end
            end
         end
         ST_DEPTH: begin
            // depth read of the parent is in flight
            state_in = ST_UPD;
         end
         ST_UPD: begin
            cw_en   = 1'b1;
            cw_addr = pick_ff;
            cw_data = pick_cnt_ff + NODE_W'(1);
            dw_en   = 1'b1;
            dw_addr = new_idx;
            dw_data = new_depth;
            if (new_depth > maxd_ff) begin
               maxd_in = new_depth;
            end
            rsp_strobe_in  = 1'b1;
            rsp_new_in     = OUT_W'(node_total_ff);
            rsp_parent_in  = OUT_W'(pick_ff);
            rsp_depth_in   = OUT_W'(new_depth);
            rsp_deepest_in = (new_depth > maxd_ff) ? OUT_W'(new_depth) : OUT_W'(maxd_ff);
            rsp_full_in    = 1'b0;
            state_in       = ST_NEW;
         end
         ST_NEW: begin
            // new node starts childless; advance totals
            cw_en         = 1'b1;
            cw_addr       = new_idx;
            cw_data       = '0;
            node_total_in = node_total_ff + TOTAL_W'(1);
            ws_in         = ws_ff + WS_W'(WEIGHT_STEP);
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         node_total_ff <= TOTAL_W'(1);
         ws_ff         <= WS_W'(ROOT_WEIGHT);
         maxd_ff       <= '0;
         limit_ff      <= LIMIT_RESET;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_total_ff <= node_total_in;
         ws_ff         <= ws_in;
         maxd_ff       <= maxd_in;
         limit_ff      <= limit_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      token_ff       <= token_in;
      acc_ff         <= acc_in;
      issue_ff       <= issue_in;
      pend_idx_ff    <= pend_idx_in;
      pick_ff        <= pick_in;
      pick_cnt_ff    <= pick_cnt_in;
      rsp_new_ff     <= rsp_new_in;
      rsp_parent_ff  <= rsp_parent_in;
      rsp_depth_ff   <= rsp_depth_in;
      rsp_deepest_ff <= rsp_deepest_in;
      rsp_full_ff    <= rsp_full_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_new_node    = rsp_new_ff;
   assign rsp_parent_node = rsp_parent_ff;
   assign rsp_node_depth  = rsp_depth_ff;
   assign rsp_deepest     = rsp_deepest_ff;
   assign rsp_full_res    = rsp_full_ff;

   // weight sum always equals the sum of child counts plus two per node
   a_weight_sum: assert property (@(posedge clock) disable iff (reset)
      32'(ws_ff) == 3 * 32'(node_total_ff) - 1)
      else $error("weight sum out of step with node total");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) && pend_ff |-> 32'(pend_idx_ff) < 32'(node_total_ff))
      else $error("walk read past the last node");

   a_depth_le_deepest: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && !rsp_full_ff |-> rsp_depth_ff <= rsp_deepest_ff)
      else $error("new depth above deepest");

   a_grow_goes_busy: assert property (@(posedge clock) disable iff (reset)
      accept && !tree_full |=> busy && !rsp_strobe)
      else $error("growth transaction did not start work");

   a_full_answers: assert property (@(posedge clock) disable iff (reset)
      accept && tree_full |=> rsp_strobe && rsp_full_res)
      else $error("full tree not reported");

endmodule
